// ===== rtl/decimal_token_accumulator_calculator_top_macros.svh =====
// Assertion helpers for the RTL that checks itself.
`ifndef DECIMAL_TOKEN_ACCUMULATOR_CALCULATOR_TOP_MACROS_SVH
`define DECIMAL_TOKEN_ACCUMULATOR_CALCULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTAC_ASSERT_IMPL(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define DTAC_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/dtac_pkg.sv =====
package dtac_pkg;

    localparam int TOTAL_BITS      = 48;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int FCNT_W          = 3;
    localparam int TEN_W           = 24;

    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_EQ  = 3'd5;
    localparam logic [2:0] OP_BAD = 3'd6;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;
    localparam logic [1:0] ST_SAT = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_token;
    } in_item_t;

    typedef struct packed {
        logic signed [TOTAL_BITS-1:0] running_total;
        logic                         is_final;
        logic [1:0]                   status;
    } out_item_t;

    // One finished token, handed from the parser to the execute side.
    typedef struct packed {
        logic [2:0]            op;
        logic                  first;
        logic [TOTAL_BITS-1:0] mant;
        logic [FCNT_W-1:0]     fcnt;
        logic                  nsat;
    } cmd_t;

    function automatic logic [TEN_W-1:0] pow10(input logic [FCNT_W-1:0] k);
        logic [TEN_W-1:0] p;
        unique case (k)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            3'd7: p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/dtac_front.sv =====
module dtac_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtac_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output dtac_pkg::cmd_t    q_cmd
);
    import dtac_pkg::*;

    logic [TOTAL_BITS-1:0] mant_reg, mant_next;
    logic [FCNT_W-1:0]     fcnt_reg, fcnt_next;
    logic                  point_reg, point_next;
    logic                  nsat_reg, nsat_next;
    logic [2:0]            op_reg, op_next;
    logic                  start_reg, await_reg;
    logic                  consumed, accept;
    logic [7:0]            c;
    logic [TOTAL_BITS+3:0] times10;

    assign c       = s_data.char_code;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mant_next  = mant_reg;
        fcnt_next  = fcnt_reg;
        point_next = point_reg;
        nsat_next  = nsat_reg;
        op_next    = op_reg;
        consumed   = 1'b0;
        if (start_reg) begin
            mant_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            nsat_next  = 1'b0;
            if (await_reg) begin
                op_next  = (c == CH_MINUS) ? OP_SUB : OP_ADD;
                consumed = (c == CH_MINUS) || (c == CH_PLUS);
            end else begin
                consumed = 1'b1;
                priority if (c == CH_PLUS)  op_next = OP_ADD;
                else if (c == CH_MINUS)     op_next = OP_SUB;
                else if (c == CH_STAR)      op_next = OP_MUL;
                else if (c == CH_SLASH)     op_next = OP_DIV;
                else if (c == CH_EQ)        op_next = OP_EQ;
                else                        op_next = OP_BAD;
            end
        end
        times10 = {1'b0, mant_next, 3'b000} + {3'b000, mant_next, 1'b0};
        if (!consumed && op_next != OP_EQ) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!(point_next && fcnt_next >= FCNT_W'(MAX_FRAC_DIGITS))) begin
                    // Overflow of the mantissa sets the sticky flag and leaves the mantissa unchanged.
                    if (((times10 + {{(TOTAL_BITS){1'b0}}, c[3:0]}) >> TOTAL_BITS) != '0) begin
                        nsat_next = 1'b1;
                    end else begin
                        mant_next = times10[TOTAL_BITS-1:0]
                                  + {{(TOTAL_BITS-4){1'b0}}, c[3:0]};
                    end
                    if (point_next) fcnt_next = fcnt_next + 1'b1;
                end
            end else if (c == CH_POINT) begin
                point_next = 1'b1;
            end
        end
    end

    assign q_push     = accept && s_data.end_of_token;
    assign q_cmd.op    = op_next;
    assign q_cmd.first = await_reg;
    assign q_cmd.mant  = mant_next;
    assign q_cmd.fcnt  = fcnt_next;
    assign q_cmd.nsat  = nsat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mant_reg  <= '0;
            fcnt_reg  <= '0;
            point_reg <= 1'b0;
            nsat_reg  <= 1'b0;
            op_reg    <= OP_ADD;
            start_reg <= 1'b1;
            await_reg <= 1'b1;
        end else if (accept) begin
            mant_reg  <= mant_next;
            fcnt_reg  <= fcnt_next;
            point_reg <= point_next;
            nsat_reg  <= nsat_next;
            op_reg    <= op_next;
            start_reg <= s_data.end_of_token;
            if (s_data.end_of_token) await_reg <= (op_next == OP_EQ);
        end
    end
endmodule

// ===== rtl/dtac_queue.sv =====
module dtac_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dtac_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output dtac_pkg::cmd_t pop_cmd
);
    import dtac_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_cmd   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/dtac_back.sv =====
module dtac_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  dtac_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output dtac_pkg::out_item_t m_data
);
    import dtac_pkg::*;

    localparam int TW    = TOTAL_BITS;
    localparam int HW    = TW / 2;
    localparam int DVW   = TW + FRAC_BITS + 1;
    localparam int PW    = 2 * TW;
    localparam int CNTW  = $clog2(DVW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPND = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MULF = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    localparam logic [TW-1:0] MAXPOS = {1'b0, {(TW-1){1'b1}}};

    logic [2:0]     state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [TW-1:0]  acc_reg, acc_next, base_reg, base_next, opnd_reg, opnd_next;
    logic           sat_reg, sat_next;
    logic [TW-1:0]  rem_reg, rem_next, dsr_reg, dsr_next;
    logic [DVW-1:0] dvd_reg, dvd_next, quo_reg, quo_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [1:0]     mstep_reg, mstep_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_reg, out_next;

    logic [TW:0]    trial, trial_diff, sum_ext, dif_ext;
    logic           trial_ge;
    logic [TW-1:0]  mag;
    logic           neg;
    logic [HW-1:0]  xs, bs;
    logic [TW-1:0]  pp;
    logic [PW-1:0]  pp_sh, mrnd;
    logic [DVW:0]   qrnd;
    logic [TEN_W-1:0] p10;

    function automatic logic [TW:0] clamp(input logic n, input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [PW-1:0] v;
        logic          s;
        lim = n ? {{(PW-TW){1'b0}}, MAXPOS} + 1'b1 : {{(PW-TW){1'b0}}, MAXPOS};
        v   = m;
        s   = 1'b0;
        if (m > lim) begin
            v = lim;
            s = 1'b1;
        end
        return {s, n ? (~v[TW-1:0] + 1'b1) : v[TW-1:0]};
    endfunction

    // Restoring divider, one quotient bit a cycle.
    assign trial      = {rem_reg, dvd_reg[DVW-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign trial_ge   = trial >= {1'b0, dsr_reg};

    assign neg  = base_reg[TW-1];
    assign mag  = neg ? (~base_reg + 1'b1) : base_reg;
    assign xs   = mstep_reg[1] ? mag[TW-1:HW] : mag[HW-1:0];
    assign bs   = mstep_reg[0] ? opnd_reg[TW-1:HW] : opnd_reg[HW-1:0];
    assign pp   = {{HW{1'b0}}, xs} * {{HW{1'b0}}, bs};
    assign pp_sh = {{(PW-TW){1'b0}}, pp}
                 << (HW * ({1'b0, mstep_reg[1]} + {1'b0, mstep_reg[0]}));
    assign mrnd = (prod_reg + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign qrnd = {1'b0, quo_reg} + {{DVW{1'b0}}, ({rem_reg, 1'b0} >= {1'b0, dsr_reg})};
    assign sum_ext = {base_reg[TW-1], base_reg} + {1'b0, opnd_reg};
    assign dif_ext = {base_reg[TW-1], base_reg} - {1'b0, opnd_reg};
    assign p10  = pow10(q_cmd.fcnt);

    assign q_pop   = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [TW:0] cl;
        cl             = '0;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        opnd_next      = opnd_reg;
        sat_next       = sat_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        mstep_next     = mstep_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    cmd_next  = q_cmd;
                    base_next = q_cmd.first ? '0 : acc_reg;
                    if (q_cmd.op == OP_EQ || q_cmd.op == OP_BAD) begin
                        out_valid_next         = 1'b1;
                        out_next.running_total = acc_reg;
                        out_next.is_final      = (q_cmd.op == OP_EQ);
                        out_next.status        = (q_cmd.op == OP_EQ) ? ST_OK : ST_BAD;
                    end else begin
                        // Operand = round(mant * 2^F / 10^k), ties up.
                        dvd_next   = {1'b0, q_cmd.mant, {FRAC_BITS{1'b0}}}
                                   + {{(DVW-TEN_W){1'b0}}, p10 >> 1};
                        dsr_next   = {{(TW-TEN_W){1'b0}}, p10};
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = CNTW'(DVW);
                        state_next = S_OPND;
                    end
                end
            end
            S_OPND, S_DIV: begin
                if (cnt_reg != '0) begin
                    rem_next = trial_ge ? trial_diff[TW-1:0] : trial[TW-1:0];
                    quo_next = {quo_reg[DVW-2:0], trial_ge};
                    dvd_next = {dvd_reg[DVW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end else if (state_reg == S_OPND) begin
                    sat_next   = cmd_reg.nsat || (quo_reg > {{(DVW-TW){1'b0}}, MAXPOS});
                    opnd_next  = sat_next ? MAXPOS : quo_reg[TW-1:0];
                    state_next = S_EXEC;
                end else begin
                    cl = clamp(neg, {{(PW-DVW-1){1'b0}}, qrnd});
                    acc_next               = cl[TW-1:0];
                    out_valid_next         = 1'b1;
                    out_next.running_total = cl[TW-1:0];
                    out_next.is_final      = 1'b0;
                    out_next.status        = (sat_reg || cl[TW]) ? ST_SAT : ST_OK;
                    state_next             = S_IDLE;
                end
            end
            S_EXEC: begin
                out_next.is_final = 1'b0;
                unique case (cmd_reg.op)
                    OP_ADD: begin
                        cl = (!sum_ext[TW] && sum_ext[TW-1]) ? {1'b1, MAXPOS}
                                                             : {1'b0, sum_ext[TW-1:0]};
                    end
                    OP_SUB: begin
                        cl = (dif_ext[TW] && !dif_ext[TW-1]) ? {1'b1, ~MAXPOS}
                                                             : {1'b0, dif_ext[TW-1:0]};
                    end
                    default: cl = '0;
                endcase
                priority if (cmd_reg.op == OP_ADD || cmd_reg.op == OP_SUB) begin
                    acc_next               = cl[TW-1:0];
                    out_valid_next         = 1'b1;
                    out_next.running_total = cl[TW-1:0];
                    out_next.status        = (sat_reg || cl[TW]) ? ST_SAT : ST_OK;
                    state_next             = S_IDLE;
                end else if (cmd_reg.op == OP_MUL) begin
                    prod_next  = '0;
                    mstep_next = '0;
                    state_next = S_MUL;
                end else if (opnd_reg == '0) begin
                    out_valid_next         = 1'b1;
                    out_next.running_total = acc_reg;
                    out_next.status        = ST_DZ;
                    state_next             = S_IDLE;
                end else begin
                    dvd_next   = {1'b0, mag, {FRAC_BITS{1'b0}}};
                    dsr_next   = opnd_reg;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CNTW'(DVW);
                    state_next = S_DIV;
                end
            end
            S_MUL: begin
                prod_next  = prod_reg + pp_sh;
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 2'd3) state_next = S_MULF;
            end
            S_MULF: begin
                cl = clamp(neg, mrnd);
                acc_next               = cl[TW-1:0];
                out_valid_next         = 1'b1;
                out_next.running_total = cl[TW-1:0];
                out_next.is_final      = 1'b0;
                out_next.status        = (sat_reg || cl[TW]) ? ST_SAT : ST_OK;
                state_next             = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        base_reg  <= base_next;
        opnd_reg  <= opnd_next;
        sat_reg   <= sat_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        mstep_reg <= mstep_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/decimal_token_accumulator_calculator_top.sv =====
// Channel  | Ports                      | Transaction
// ---------+----------------------------+--------------------------------------
// input    | s_valid, s_ready, s_data   | one character, end_of_token mark
// result   | m_valid, m_ready, m_data   | total, is_final, status per token
//
// Characters are taken one per cycle while the two-entry token queue has room.
// A '=' or a bad operator is answered straight from the idle state; +, - and * first
// scale the operand by a 65-step bit-serial divide, and / adds a second such divide.
// Reset (aresetn low, synchronous) empties the queue and clears the total.
// The parser keeps taking characters while a result waits on m_ready, until the queue fills.
`include "decimal_token_accumulator_calculator_top_macros.svh"

module decimal_token_accumulator_calculator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtac_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dtac_pkg::out_item_t m_data
);
    import dtac_pkg::*;

    logic q_full, q_push, q_pop, q_nonempty;
    cmd_t push_cmd, pop_cmd;

    // Parse characters and hand off each finished token.
    dtac_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // Hold tokens so parsing and arithmetic stall on their own.
    dtac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_nonempty),
        .pop_cmd   (pop_cmd)
    );

    // Apply each token to the accumulator and drive the result register.
    dtac_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_nonempty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `DTAC_ASSERT_IMPL(a_no_push_full, aclk, aresetn, q_push, !q_full)
    `DTAC_ASSERT_IMPL(a_final_ok, aclk, aresetn, m_valid && m_data.is_final, m_data.status == ST_OK)
    `DTAC_ASSERT_NEXT(a_pop_no_result, aclk, aresetn, q_pop, !m_valid || m_data.is_final || m_data.status == ST_BAD)
endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtac_pkg::*;

    localparam int TB = TOTAL_BITS;
    localparam logic [TB-1:0] TMASK = {TB{1'b1}};
    localparam logic [TB-1:0] MAXPOS = TMASK >> 1;
    localparam longint LIMIT = 3_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    always #2 aclk = ~aclk;

    decimal_token_accumulator_calculator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state, mirrors the block's parser and accumulator.
    logic signed [63:0] acc_q;
    logic [2:0] pend_op;
    logic [63:0] mant_q;
    int unsigned fdig_q;
    bit point_q, tok_start_q, first_q, nsat_q;

    out_item_t totals_q[$];
    int errors = 0;
    longint cycle = 0;
    bit idle_en = 1'b1;
    bit hold_off = 1'b0;
    int ready_gap = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at cycle %0d: %s", cycle, what);
    endtask

    function automatic logic [63:0] pow10_val(input int unsigned k);
        logic [63:0] p;
        p = 1;
        for (int i = 0; i < k; i++) p = p * 10;
        return p;
    endfunction

    function automatic logic signed [63:0] clamp_mag(input bit neg, input logic [127:0] mag,
                                                     inout bit sat);
        logic [127:0] lim;
        lim = neg ? {80'b0, MAXPOS} + 1 : {80'b0, MAXPOS};
        if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
        end
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic logic [63:0] operand_q(inout bit sat);
        logic [63:0] p, q, r, v;
        p = pow10_val(fdig_q & 7);
        q = mant_q / p;
        r = mant_q % p;
        if (nsat_q || q > (MAXPOS >> FRAC_BITS)) begin
            sat = 1'b1;
            return MAXPOS;
        end
        v = (q << FRAC_BITS) + (((r << FRAC_BITS) + p / 2) / p);
        if (v > MAXPOS) begin
            sat = 1'b1;
            return MAXPOS;
        end
        return v;
    endfunction

    // Advance the predictor by one character; push a total at token end.
    task automatic predict_char(input logic [7:0] c, input bit eot);
        bit consumed, sat, fin;
        logic [1:0] st;
        logic [63:0] b, d;
        logic signed [63:0] a;
        logic [127:0] x, prod, num, qq, rem;
        out_item_t o;
        consumed = 0; sat = 0; fin = 0; st = ST_OK;
        if (tok_start_q) begin
            tok_start_q = 0; mant_q = 0; fdig_q = 0; point_q = 0; nsat_q = 0;
            if (first_q) begin
                acc_q = 0;
                pend_op = (c == CH_MINUS) ? OP_SUB : OP_ADD;
                consumed = (c == CH_MINUS) || (c == CH_PLUS);
            end else begin
                consumed = 1;
                case (c)
                    CH_PLUS: pend_op = OP_ADD;
                    CH_MINUS: pend_op = OP_SUB;
                    CH_STAR: pend_op = OP_MUL;
                    CH_SLASH: pend_op = OP_DIV;
                    CH_EQ: pend_op = OP_EQ;
                    default: pend_op = OP_BAD;
                endcase
            end
        end
        if (!consumed && pend_op != OP_EQ) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                if (!(point_q && fdig_q >= MAX_FRAC_DIGITS)) begin
                    if (mant_q > ({16'b0, TMASK} - d) / 10) nsat_q = 1;
                    else mant_q = mant_q * 10 + d;
                    if (point_q) fdig_q++;
                end
            end else if (c == CH_POINT) begin
                point_q = 1;
            end
        end
        if (!eot) return;
        tok_start_q = 1;
        if (pend_op == OP_EQ) begin
            fin = 1;
            first_q = 1;
        end else begin
            b = operand_q(sat);
            a = acc_q;
            first_q = 0;
            x = (a < 0) ? 128'(-a) : 128'(a);
            case (pend_op)
                OP_ADD: begin
                    if (a > $signed({16'b0, MAXPOS}) - $signed(b)) begin
                        a = {16'b0, MAXPOS}; sat = 1;
                    end else a = a + $signed(b);
                end
                OP_SUB: begin
                    if (a < -$signed({16'b0, MAXPOS}) - 1 + $signed(b)) begin
                        a = -$signed({16'b0, MAXPOS}) - 1; sat = 1;
                    end else a = a - $signed(b);
                end
                OP_MUL: begin
                    prod = (x * b + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    a = clamp_mag(a < 0, prod, sat);
                end
                OP_DIV: begin
                    if (b == 0) st = ST_DZ;
                    else begin
                        num = x << FRAC_BITS;
                        qq = num / b;
                        rem = num % b;
                        if (rem >= b - rem) qq++;
                        a = clamp_mag(a < 0, qq, sat);
                    end
                end
                default: st = ST_BAD;
            endcase
            if (st == ST_OK) begin
                acc_q = a;
                if (sat) st = ST_SAT;
            end
        end
        o.running_total = acc_q[TB-1:0];
        o.is_final = fin;
        o.status = st;
        totals_q.push_back(o);
    endtask

    // Send one transaction; random gaps ahead of it while idling is enabled.
    task automatic send_char(input logic [7:0] c, input bit eot);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{char_code: c, end_of_token: eot};
        do @(posedge aclk); while (!s_ready);
        predict_char(c, eot);
    endtask

    task automatic send_token(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (totals_q.size() != 0) @(posedge aclk);
    endtask

    // Check each result transaction against the oldest expected total.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (totals_q.size() == 0) report_mismatch("result with none expected");
            else begin
                out_item_t e;
                e = totals_q.pop_front();
                if (m_data.running_total !== e.running_total)
                    report_mismatch($sformatf("total %h exp %h",
                        m_data.running_total, e.running_total));
                if (m_data.is_final !== e.is_final)
                    report_mismatch($sformatf("is_final %b exp %b", m_data.is_final, e.is_final));
                if (m_data.status !== e.status)
                    report_mismatch($sformatf("status %0d exp %0d", m_data.status, e.status));
            end
        end
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (hold_off) m_ready <= 1'b0;
        else if (ready_gap > 0) begin
            m_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            ready_gap <= int'($urandom_range(0, 17));
        end else m_ready <= 1'b1;
        if (cycle > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic string rand_number(input bit allow_sign);
        string s;
        int nd;
        s = "";
        if (allow_sign && $urandom_range(0, 3) == 0) s = ($urandom_range(0, 1)) ? "-" : "+";
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
        for (int i = 0; i < nd; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        if ($urandom_range(0, 1)) begin
            s = {s, "."};
            nd = $urandom_range(0, 8);
            for (int i = 0; i < nd; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        end
        if ($urandom_range(0, 15) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
        if (s.len() == 0) s = "0";
        return s;
    endfunction

    task automatic test_directed();
        send_token("999999999");
        send_token("*999999");
        send_token("=");
        send_token("-140737488355328");
        send_token("-1");
        send_token("*2.5");
        send_token("/0");
        send_token("/");
        send_token("%7");
        send_token("/3.1234567");
        send_token("+1..5a");
        send_token("=junk");
        send_token("=");
        send_token("+0.000008");
        send_token("=");
        wait_drain();
    endtask

    task automatic test_random(input int n_items);
        int sent;
        string ops;
        string t;
        ops = "+-*/=+-*x";
        sent = 0;
        while (sent < n_items) begin
            t = rand_number(1);
            send_token(t);
            sent += t.len();
            for (int k = $urandom_range(0, 6); k > 0; k--) begin
                t = {string'(ops[$urandom_range(0, 8)]), rand_number(0)};
                send_token(t);
                sent += t.len();
            end
            t = ($urandom_range(0, 3) != 0) ? "=" : "=x";
            send_token(t);
            sent += t.len();
            // random raw bytes now and then
            if ($urandom_range(0, 5) == 0) begin
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    sent++;
                end
                send_char(CH_EQ, 1'b1);
                sent++;
            end
        end
    endtask

    // Hold the receiver off so the token queue fills and s_ready drops.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        acc_q = 0; pend_op = OP_ADD; mant_q = 0; fdig_q = 0;
        point_q = 0; tok_start_q = 1; first_q = 1; nsat_q = 0;
        test_directed();
        test_backpressure();
        test_random(1400);
        wait_drain();
        idle_en = 1'b0;
        test_random(400);
        wait_drain();
        repeat (300) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
